### hw/rtl/space_vector_pwm_duty_assert.svh
// Assertion macros for the space vector PWM duty RTL
`ifndef SPACE_VECTOR_PWM_DUTY_ASSERT_SVH
`define SPACE_VECTOR_PWM_DUTY_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define SVPD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svpd assertion failed");

// Check that a condition implies another in the next cycle
`define SVPD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svpd assertion failed");

`endif

### hw/rtl/svpd_pkg.sv
// Shared types, constants and the sector decode for the SVPWM duty block
package svpd_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_VBUS_GAIN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DUTY   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DUTY   = 3'd3;

    // Register reset values
    localparam logic [15:0] RST_VBUS_GAIN  = 16'd4096;
    localparam logic [15:0] RST_PWM_PERIOD = 16'd5000;
    localparam logic [15:0] RST_MAX_DUTY   = 16'd62259;
    localparam logic [15:0] RST_MIN_DUTY   = 16'd3277;

    // sqrt(3) in Q16
    localparam int SQRT3_Q16 = 113512;

    // Active times are shifted down until their sum is below 2^NORM_LIMIT
    localparam int NORM_LIMIT = 38;

    // Sector codes
    localparam logic [2:0] SECTOR_ZERO = 3'd0;
    localparam logic [2:0] SECTOR_1    = 3'd1;
    localparam logic [2:0] SECTOR_2    = 3'd2;
    localparam logic [2:0] SECTOR_3    = 3'd3;
    localparam logic [2:0] SECTOR_4    = 3'd4;
    localparam logic [2:0] SECTOR_5    = 3'd5;
    localparam logic [2:0] SECTOR_6    = 3'd6;

    typedef struct packed {
        logic [15:0] vbus_gain;
        logic [15:0] pwm_period;
        logic [15:0] max_duty;
        logic [15:0] min_duty;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_NORM,
        ST_DIV,
        ST_DUTY,
        ST_MUL
    } back_state_t;

    // Map sign code {y<0, z<0, x>0} to the sector number
    function automatic logic [2:0] sector_of_code(input logic [2:0] code);
        logic [2:0] s;
        unique case (code)
            3'd1:    s = SECTOR_2;
            3'd2:    s = SECTOR_6;
            3'd3:    s = SECTOR_1;
            3'd4:    s = SECTOR_4;
            3'd5:    s = SECTOR_3;
            3'd6:    s = SECTOR_5;
            default: s = SECTOR_ZERO;
        endcase
        return s;
    endfunction

endpackage

### hw/rtl/space_vector_pwm_duty.sv
// Top level of the seven-segment space vector PWM duty generator
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  input    | in_valid / in_stall | v_alpha, v_beta
//  output   | out_valid/out_stall | duty_a..c, compare_a..c, sector, overmodulated
//  config   | cfg_we              | cfg_index, cfg_data
//
// The front pipeline takes one request per cycle unless stalled, through stages A to E into
// a four-entry queue. The back unit takes one request at a time through IDLE, CHECK, DUTY
// and MUL; an overmodulated request also passes NORM, with one shift per bit of t1 + t2 at
// or above bit 38 (none at the default widths), and DIV for FRAC_BITS + 1 divider steps.
// Reset clears all control state at once; there is no clearing pass.
// A stalled output holds its result; the front keeps filling the queue meanwhile.
module space_vector_pwm_duty #(
    parameter int VOLT_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [VOLT_WIDTH-1:0]         v_alpha,
    input  logic signed [VOLT_WIDTH-1:0]         v_beta,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [15:0]                          duty_a,
    output logic [15:0]                          duty_b,
    output logic [15:0]                          duty_c,
    output logic [15:0]                          compare_a,
    output logic [15:0]                          compare_b,
    output logic [15:0]                          compare_c,
    output logic [2:0]                           sector,
    output logic                                 overmodulated,
    input  logic                                 cfg_we,
    input  logic [svpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [15:0]                          cfg_data
);

    localparam int TIME_W  = VOLT_WIDTH + 34 - (41 - FRAC_BITS);
    localparam int ENTRY_W = 2 * TIME_W + 3;

    svpd_pkg::cfg_t cfg_reg;

    logic               push, pop, full, empty;
    logic [TIME_W-1:0]  push_t1, push_t2;
    logic [2:0]         push_sector;
    logic [ENTRY_W-1:0] pop_data;

    // Write configuration registers; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vbus_gain  <= svpd_pkg::RST_VBUS_GAIN;
            cfg_reg.pwm_period <= svpd_pkg::RST_PWM_PERIOD;
            cfg_reg.max_duty   <= svpd_pkg::RST_MAX_DUTY;
            cfg_reg.min_duty   <= svpd_pkg::RST_MIN_DUTY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                svpd_pkg::CFG_VBUS_GAIN:  cfg_reg.vbus_gain  <= cfg_data;
                svpd_pkg::CFG_PWM_PERIOD: cfg_reg.pwm_period <= cfg_data;
                svpd_pkg::CFG_MAX_DUTY:   cfg_reg.max_duty   <= cfg_data;
                svpd_pkg::CFG_MIN_DUTY:   cfg_reg.min_duty   <= cfg_data;
                default:                  cfg_reg            <= cfg_reg;
            endcase
        end
    end

    svpd_front #(
        .VOLT_WIDTH (VOLT_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .TIME_W     (TIME_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .v_alpha     (v_alpha),
        .v_beta      (v_beta),
        .gain        (cfg_reg.vbus_gain),
        .full        (full),
        .push        (push),
        .push_t1     (push_t1),
        .push_t2     (push_t2),
        .push_sector (push_sector)
    );

    svpd_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_t1, push_t2, push_sector}),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    svpd_back #(
        .FRAC_BITS (FRAC_BITS),
        .TIME_W    (TIME_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .empty         (empty),
        .pop           (pop),
        .pop_t1        (pop_data[ENTRY_W-1:TIME_W+3]),
        .pop_t2        (pop_data[TIME_W+2:3]),
        .pop_sector    (pop_data[2:0]),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .duty_a        (duty_a),
        .duty_b        (duty_b),
        .duty_c        (duty_c),
        .compare_a     (compare_a),
        .compare_b     (compare_b),
        .compare_c     (compare_c),
        .sector        (sector),
        .overmodulated (overmodulated)
    );

endmodule

### hw/rtl/svpd_front.sv
// Front pipeline: sector quantities, sector decode and scaled active times
module svpd_front #(
    parameter int VOLT_WIDTH = 16,
    parameter int FRAC_BITS  = 16,
    parameter int TIME_W     = 25
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [VOLT_WIDTH-1:0] v_alpha,
    input  logic signed [VOLT_WIDTH-1:0] v_beta,
    input  logic [15:0]                  gain,
    input  logic                         full,
    output logic                         push,
    output logic [TIME_W-1:0]            push_t1,
    output logic [TIME_W-1:0]            push_t2,
    output logic [2:0]                   push_sector
);

    localparam int Q_W    = VOLT_WIDTH + 20;
    localparam int MAG_W  = VOLT_WIDTH + 18;
    localparam int HI_W   = MAG_W / 2;
    localparam int LO_W   = MAG_W - HI_W;
    localparam int PROD_W = MAG_W + 16;
    localparam int SHIFT  = 41 - FRAC_BITS;
    localparam logic signed [Q_W-1:0] SQRT3 = Q_W'(svpd_pkg::SQRT3_Q16);

    logic advance;

    logic                  a_valid_reg;
    logic signed [Q_W-1:0] a_sv_reg, a_tv_reg;

    logic                  b_valid_reg;
    logic signed [Q_W-1:0] b_x_reg, b_y_reg, b_z_reg;
    logic [2:0]            b_sector_reg;

    logic                  c_valid_reg;
    logic [MAG_W-1:0]      c_m1_reg, c_m2_reg;
    logic [2:0]            c_sector_reg;

    logic                  d_valid_reg;
    logic [LO_W+15:0]      d_pl1_reg, d_pl2_reg;
    logic [HI_W+15:0]      d_ph1_reg, d_ph2_reg;
    logic [2:0]            d_sector_reg;

    logic                  e_valid_reg;
    logic [TIME_W-1:0]     e_t1_reg, e_t2_reg;
    logic [2:0]            e_sector_reg;

    logic signed [Q_W-1:0] sv_next, tv_next;
    logic signed [Q_W-1:0] x_next, y_next, z_next;
    logic [2:0]            code;
    logic signed [Q_W-1:0] p_sel, q_sel;
    logic [PROD_W-1:0]     full1, full2;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [Q_W-1:0] v);
        logic signed [Q_W-1:0] n;
        n = v[Q_W-1] ? -v : v;
        return MAG_W'(n);
    endfunction

    // Advance the whole pipeline unless the last stage is blocked
    assign advance     = !e_valid_reg || !full;
    assign in_stall    = !advance;
    assign push        = e_valid_reg && !full;
    assign push_t1     = e_t1_reg;
    assign push_t2     = e_t2_reg;
    assign push_sector = e_sector_reg;

    // Stage A: sqrt3 * vb and 3 * va in Q16
    assign sv_next = Q_W'(v_beta) * SQRT3;
    assign tv_next = (Q_W'(v_alpha) <<< 17) + (Q_W'(v_alpha) <<< 16);

    // Stage B: doubled X, Y, Z and their sign code
    assign x_next = a_sv_reg <<< 1;
    assign y_next = a_tv_reg + a_sv_reg;
    assign z_next = a_sv_reg - a_tv_reg;
    assign code   = {y_next[Q_W-1], z_next[Q_W-1],
                     !a_sv_reg[Q_W-1] && (a_sv_reg != '0)};

    // Stage C: pick the pair of quantities for this sector
    always_comb
    begin
        case (b_sector_reg) inside
            svpd_pkg::SECTOR_1, svpd_pkg::SECTOR_4:
            begin
                p_sel = b_z_reg;
                q_sel = b_x_reg;
            end
            svpd_pkg::SECTOR_2, svpd_pkg::SECTOR_5:
            begin
                p_sel = b_y_reg;
                q_sel = b_z_reg;
            end
            svpd_pkg::SECTOR_3, svpd_pkg::SECTOR_6:
            begin
                p_sel = b_x_reg;
                q_sel = b_y_reg;
            end
            default:
            begin
                p_sel = '0;
                q_sel = '0;
            end
        endcase
    end

    // Stage E: combine the partial products and drop the fraction
    assign full1 = (PROD_W'(d_ph1_reg) << LO_W) + PROD_W'(d_pl1_reg);
    assign full2 = (PROD_W'(d_ph2_reg) << LO_W) + PROD_W'(d_pl2_reg);

    // Hold valid flags under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // Advance the payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_sv_reg     <= sv_next;
            a_tv_reg     <= tv_next;
            b_x_reg      <= x_next;
            b_y_reg      <= y_next;
            b_z_reg      <= z_next;
            b_sector_reg <= svpd_pkg::sector_of_code(code);
            c_m1_reg     <= mag_of(p_sel);
            c_m2_reg     <= mag_of(q_sel);
            c_sector_reg <= b_sector_reg;
            d_pl1_reg    <= (LO_W+16)'(c_m1_reg[LO_W-1:0]) * (LO_W+16)'(gain);
            d_pl2_reg    <= (LO_W+16)'(c_m2_reg[LO_W-1:0]) * (LO_W+16)'(gain);
            d_ph1_reg    <= (HI_W+16)'(c_m1_reg[MAG_W-1:LO_W]) * (HI_W+16)'(gain);
            d_ph2_reg    <= (HI_W+16)'(c_m2_reg[MAG_W-1:LO_W]) * (HI_W+16)'(gain);
            d_sector_reg <= c_sector_reg;
            e_t1_reg     <= TIME_W'(full1 >> SHIFT);
            e_t2_reg     <= TIME_W'(full2 >> SHIFT);
            e_sector_reg <= d_sector_reg;
        end
    end

endmodule

### hw/rtl/svpd_queue.sv
// Small request queue between the front pipeline and the back unit
module svpd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the pushed request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/svpd_back.sv
// Back unit: overmodulation rescale, duty build, clamp and compare counts
`include "space_vector_pwm_duty_assert.svh"

module svpd_back #(
    parameter int FRAC_BITS = 16,
    parameter int TIME_W    = 25
) (
    input  logic                clk,
    input  logic                rst_n,
    input  svpd_pkg::cfg_t      cfg,
    input  logic                empty,
    output logic                pop,
    input  logic [TIME_W-1:0]   pop_t1,
    input  logic [TIME_W-1:0]   pop_t2,
    input  logic [2:0]          pop_sector,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [15:0]         duty_a,
    output logic [15:0]         duty_b,
    output logic [15:0]         duty_c,
    output logic [15:0]         compare_a,
    output logic [15:0]         compare_b,
    output logic [15:0]         compare_c,
    output logic [2:0]          sector,
    output logic                overmodulated
);

    localparam int SUM_W = TIME_W + 1;
    localparam int REM_W = svpd_pkg::NORM_LIMIT + 2;
    localparam int D_W   = FRAC_BITS + 2;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam int ONE   = 1 << FRAC_BITS;

    svpd_pkg::back_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;

    logic [TIME_W-1:0] t1_reg, t1_next, t2_reg, t2_next;
    logic [2:0]        sec_reg, sec_next;
    logic              over_reg, over_next;
    logic [REM_W-1:0]  rem1_reg, rem1_next, rem2_reg, rem2_next, div_reg, div_next;
    logic [Q_W-1:0]    q1_reg, q1_next, q2_reg, q2_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [15:0]       da_reg, da_next, db_reg, db_next, dc_reg, dc_next;

    logic [15:0] duty_a_reg, duty_b_reg, duty_c_reg;
    logic [15:0] cmp_a_reg, cmp_b_reg, cmp_c_reg;
    logic [2:0]  sector_reg;
    logic        over_out_reg;
    logic        out_load;

    logic [SUM_W-1:0] sum_w;
    logic [REM_W-1:0] sh1, sh2;
    logic             ge1, ge2;
    logic [D_W-1:0]   t1f, t2f, base, da, db, dc;
    logic             out_free;

    function automatic logic [15:0] to_duty(input logic [D_W-1:0] d,
                                            input svpd_pkg::cfg_t c);
        logic [D_W+15:0] w;
        logic [15:0]     v;
        w = {d, 16'h0000} >> FRAC_BITS;
        v = (w > (D_W+16)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
        if (v > c.max_duty)
        begin
            v = c.max_duty;
        end
        if (v < c.min_duty)
        begin
            v = c.min_duty;
        end
        return v;
    endfunction

    function automatic logic [15:0] to_compare(input logic [15:0] d, input logic [15:0] p);
        logic [31:0] m;
        m = 32'(d) * 32'(p);
        return m[31:16];
    endfunction

    assign sum_w    = SUM_W'(t1_reg) + SUM_W'(t2_reg);
    assign out_free = !out_valid_reg || !out_stall;

    // One restoring division step for each active time
    assign sh1 = (cnt_reg == '0) ? rem1_reg : (rem1_reg << 1);
    assign sh2 = (cnt_reg == '0) ? rem2_reg : (rem2_reg << 1);
    assign ge1 = (sh1 >= div_reg);
    assign ge2 = (sh2 >= div_reg);

    // Build the centred duties from base and active times
    assign t1f  = D_W'(t1_reg);
    assign t2f  = D_W'(t2_reg);
    assign base = (D_W'(ONE) - t1f - t2f) >> 1;

    always_comb
    begin
        case (sec_reg)
            svpd_pkg::SECTOR_1:
            begin
                da = base + t1f + t2f;
                db = base + t2f;
                dc = base;
            end
            svpd_pkg::SECTOR_2:
            begin
                da = base + t1f;
                db = base + t1f + t2f;
                dc = base;
            end
            svpd_pkg::SECTOR_3:
            begin
                da = base;
                db = base + t1f + t2f;
                dc = base + t2f;
            end
            svpd_pkg::SECTOR_4:
            begin
                da = base;
                db = base + t1f;
                dc = base + t1f + t2f;
            end
            svpd_pkg::SECTOR_5:
            begin
                da = base + t2f;
                db = base;
                dc = base + t1f + t2f;
            end
            svpd_pkg::SECTOR_6:
            begin
                da = base + t1f + t2f;
                db = base;
                dc = base + t1f;
            end
            default:
            begin
                da = base;
                db = base;
                dc = base;
            end
        endcase
    end

    // Sequence one request through the back unit
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        pop            = 1'b0;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        sec_next       = sec_reg;
        over_next      = over_reg;
        rem1_next      = rem1_reg;
        rem2_next      = rem2_reg;
        div_next       = div_reg;
        q1_next        = q1_reg;
        q2_next        = q2_reg;
        cnt_next       = cnt_reg;
        da_next        = da_reg;
        db_next        = db_reg;
        dc_next        = dc_reg;
        unique case (state_reg)
            svpd_pkg::ST_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    t1_next    = pop_t1;
                    t2_next    = pop_t2;
                    sec_next   = pop_sector;
                    state_next = svpd_pkg::ST_CHECK;
                end
            end
            svpd_pkg::ST_CHECK:
            begin
                over_next  = (sum_w > SUM_W'(ONE));
                state_next = (sum_w > SUM_W'(ONE)) ? svpd_pkg::ST_NORM : svpd_pkg::ST_DUTY;
            end
            svpd_pkg::ST_NORM:
            begin
                if ((sum_w >> svpd_pkg::NORM_LIMIT) != '0)
                begin
                    t1_next = t1_reg >> 1;
                    t2_next = t2_reg >> 1;
                end
                else
                begin
                    rem1_next  = REM_W'(t1_reg);
                    rem2_next  = REM_W'(t2_reg);
                    div_next   = REM_W'(sum_w);
                    q1_next    = '0;
                    q2_next    = '0;
                    cnt_next   = '0;
                    state_next = svpd_pkg::ST_DIV;
                end
            end
            svpd_pkg::ST_DIV:
            begin
                rem1_next = ge1 ? sh1 - div_reg : sh1;
                rem2_next = ge2 ? sh2 - div_reg : sh2;
                q1_next   = {q1_reg[Q_W-2:0], ge1};
                q2_next   = {q2_reg[Q_W-2:0], ge2};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS))
                begin
                    t1_next    = TIME_W'(q1_next);
                    t2_next    = TIME_W'(q2_next);
                    state_next = svpd_pkg::ST_DUTY;
                end
            end
            svpd_pkg::ST_DUTY:
            begin
                da_next    = to_duty(da, cfg);
                db_next    = to_duty(db, cfg);
                dc_next    = to_duty(dc, cfg);
                state_next = svpd_pkg::ST_MUL;
            end
            svpd_pkg::ST_MUL:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = svpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = svpd_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold state and output valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svpd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        sec_reg  <= sec_next;
        over_reg <= over_next;
        rem1_reg <= rem1_next;
        rem2_reg <= rem2_next;
        div_reg  <= div_next;
        q1_reg   <= q1_next;
        q2_reg   <= q2_next;
        cnt_reg  <= cnt_next;
        da_reg   <= da_next;
        db_reg   <= db_next;
        dc_reg   <= dc_next;
        if (out_load)
        begin
            duty_a_reg   <= da_reg;
            duty_b_reg   <= db_reg;
            duty_c_reg   <= dc_reg;
            cmp_a_reg    <= to_compare(da_reg, cfg.pwm_period);
            cmp_b_reg    <= to_compare(db_reg, cfg.pwm_period);
            cmp_c_reg    <= to_compare(dc_reg, cfg.pwm_period);
            sector_reg   <= sec_reg;
            over_out_reg <= over_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign duty_a        = duty_a_reg;
    assign duty_b        = duty_b_reg;
    assign duty_c        = duty_c_reg;
    assign compare_a     = cmp_a_reg;
    assign compare_b     = cmp_b_reg;
    assign compare_c     = cmp_c_reg;
    assign sector        = sector_reg;
    assign overmodulated = over_out_reg;

    // The zero vector never overmodulates
    `SVPD_ASSERT_IMP(a_over_sector, clk, rst_n, out_valid_reg && over_out_reg, sector_reg != svpd_pkg::SECTOR_ZERO)
    // The last division step hands over to the duty build
    `SVPD_ASSERT_NXT(a_div_done, clk, rst_n, state_reg == svpd_pkg::ST_DIV && cnt_reg == CNT_W'(FRAC_BITS), state_reg == svpd_pkg::ST_DUTY)
    // Active times never exceed one period when duties are built
    `SVPD_ASSERT_IMP(a_time_bound, clk, rst_n, state_reg == svpd_pkg::ST_DUTY, sum_w <= SUM_W'(ONE))

endmodule

### dv/space_vector_pwm_duty_test.sv
// Self-checking testbench for the space vector PWM duty generator
`timescale 1ns / 1ps

module space_vector_pwm_duty_test;

    // First index past the defined registers; writes there must be ignored
    localparam logic [svpd_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 3'd4;
    localparam int ONE = 65536;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic signed [15:0] va;
        logic signed [15:0] vb;
        bit                 drain;
    } volt_req_t;

    typedef struct {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        logic [15:0] cmp_a;
        logic [15:0] cmp_b;
        logic [15:0] cmp_c;
        logic [2:0]  sector;
        logic        over;
    } duty_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] v_alpha = '0;
    logic signed [15:0] v_beta = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [15:0] duty_a, duty_b, duty_c, compare_a, compare_b, compare_c;
    logic [2:0] sector;
    logic overmodulated;
    logic cfg_we = 1'b0;
    logic [svpd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    volt_req_t      pending_reqs[$];
    duty_res_t      expected_duties[$];
    svpd_pkg::cfg_t shadow_cfg;
    int             fail_count = 0;
    bit             in_fire = 0;
    bit             calm = 0;
    bit             choke_start = 0;
    int             choke_left = 0;
    int             quiet_cycles = 0;

    space_vector_pwm_duty dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .v_alpha(v_alpha), .v_beta(v_beta),
        .out_valid(out_valid), .out_stall(out_stall),
        .duty_a(duty_a), .duty_b(duty_b), .duty_c(duty_c),
        .compare_a(compare_a), .compare_b(compare_b), .compare_c(compare_c),
        .sector(sector), .overmodulated(overmodulated),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Scale a doubled Q16 quantity into a period fraction
    function automatic longint unsigned period_frac(longint q);
        longint unsigned mag;
        mag = (q < 0) ? longint'(-q) : longint'(q);
        return (mag * shadow_cfg.vbus_gain) >> 25;
    endfunction

    // Clamp one duty and turn it into Q0.16
    function automatic logic [15:0] clamp_duty(longint unsigned d);
        longint unsigned v;
        v = (d > 65535) ? 65535 : d;
        if (v > shadow_cfg.max_duty) v = shadow_cfg.max_duty;
        if (v < shadow_cfg.min_duty) v = shadow_cfg.min_duty;
        return v[15:0];
    endfunction

    // Work out the duties, compares, sector and flag for one voltage vector
    function automatic duty_res_t svpwm_duties(logic signed [15:0] va, logic signed [15:0] vb);
        longint sv, tv, x2, y2, z2;
        longint unsigned t1, t2, total, base, da, db, dc, prod;
        logic [2:0] code, sec;
        duty_res_t r;
        sv = longint'(svpd_pkg::SQRT3_Q16) * longint'(vb);
        tv = 196608 * longint'(va);
        x2 = 2 * sv;
        y2 = tv + sv;
        z2 = sv - tv;
        code = {y2 < 0, z2 < 0, x2 > 0};
        case (code)
            3'd1:    sec = svpd_pkg::SECTOR_2;
            3'd2:    sec = svpd_pkg::SECTOR_6;
            3'd3:    sec = svpd_pkg::SECTOR_1;
            3'd4:    sec = svpd_pkg::SECTOR_4;
            3'd5:    sec = svpd_pkg::SECTOR_3;
            3'd6:    sec = svpd_pkg::SECTOR_5;
            default: sec = svpd_pkg::SECTOR_ZERO;
        endcase
        t1 = 0;
        t2 = 0;
        case (sec)
            svpd_pkg::SECTOR_1, svpd_pkg::SECTOR_4:
                begin t1 = period_frac(z2); t2 = period_frac(x2); end
            svpd_pkg::SECTOR_2, svpd_pkg::SECTOR_5:
                begin t1 = period_frac(y2); t2 = period_frac(z2); end
            svpd_pkg::SECTOR_3, svpd_pkg::SECTOR_6:
                begin t1 = period_frac(x2); t2 = period_frac(y2); end
            default: ;
        endcase
        total = t1 + t2;
        r.over = 1'b0;
        // Rescale active times that overrun the period
        if (total > ONE)
        begin
            r.over = 1'b1;
            while ((total >> svpd_pkg::NORM_LIMIT) != 0)
            begin
                t1 = t1 >> 1;
                t2 = t2 >> 1;
                total = t1 + t2;
            end
            t1 = (t1 * ONE) / total;
            t2 = (t2 * ONE) / total;
        end
        base = (ONE - t1 - t2) >> 1;
        case (sec)
            svpd_pkg::SECTOR_1: begin da = base + t1 + t2; db = base + t2; dc = base; end
            svpd_pkg::SECTOR_2: begin da = base + t1; db = base + t1 + t2; dc = base; end
            svpd_pkg::SECTOR_3: begin da = base; db = base + t1 + t2; dc = base + t2; end
            svpd_pkg::SECTOR_4: begin da = base; db = base + t1; dc = base + t1 + t2; end
            svpd_pkg::SECTOR_5: begin da = base + t2; db = base; dc = base + t1 + t2; end
            svpd_pkg::SECTOR_6: begin da = base + t1 + t2; db = base; dc = base + t1; end
            default:            begin da = base; db = base; dc = base; end
        endcase
        r.duty_a = clamp_duty(da);
        r.duty_b = clamp_duty(db);
        r.duty_c = clamp_duty(dc);
        prod = longint'(r.duty_a) * shadow_cfg.pwm_period;
        r.cmp_a = prod[31:16];
        prod = longint'(r.duty_b) * shadow_cfg.pwm_period;
        r.cmp_b = prod[31:16];
        prod = longint'(r.duty_c) * shadow_cfg.pwm_period;
        r.cmp_c = prod[31:16];
        r.sector = sec;
        return r;
    endfunction

    // Drive requests from the pending queue at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_reqs.size() > 0 && pending_reqs[0].drain)
            begin
                if (expected_duties.size() == 0 && !in_fire)
                    void'(pending_reqs.pop_front());
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() == 0 || (!calm && $urandom_range(0, 99) < 33))
                in_valid <= 1'b0;
            else
            begin
                volt_req_t q;
                q = pending_reqs.pop_front();
                v_alpha <= q.va;
                v_beta <= q.vb;
                in_valid <= 1'b1;
            end
        end
    end

    // Receiver stall, with a long hold-off on demand
    always @(negedge clk)
    begin
        if (choke_start)
        begin
            choke_start = 0;
            choke_left = 400;
        end
        if (choke_left > 0)
        begin
            choke_left = choke_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 33);
    end

    // Predict on accepted requests and check accepted results
    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
            expected_duties.push_back(svpwm_duties(v_alpha, v_beta));
        if (rst_n && out_valid && !out_stall)
        begin
            duty_res_t e;
            if (expected_duties.size() == 0)
            begin
                $display("%0t: unexpected result sector=%0d", $time, sector);
                fail_count++;
            end
            else
            begin
                e = expected_duties.pop_front();
                if ({duty_a, duty_b, duty_c, compare_a, compare_b, compare_c, sector,
                     overmodulated} !== {e.duty_a, e.duty_b, e.duty_c, e.cmp_a, e.cmp_b,
                     e.cmp_c, e.sector, e.over})
                begin
                    $display("%0t: mismatch expected duty %0d %0d %0d cmp %0d %0d %0d sec %0d ov %0d",
                             $time, e.duty_a, e.duty_b, e.duty_c, e.cmp_a, e.cmp_b, e.cmp_c,
                             e.sector, e.over);
                    $display("%0t:          actual duty %0d %0d %0d cmp %0d %0d %0d sec %0d ov %0d",
                             $time, duty_a, duty_b, duty_c, compare_a, compare_b, compare_c,
                             sector, overmodulated);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_duties.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [svpd_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            svpd_pkg::CFG_VBUS_GAIN:  shadow_cfg.vbus_gain = val;
            svpd_pkg::CFG_PWM_PERIOD: shadow_cfg.pwm_period = val;
            svpd_pkg::CFG_MAX_DUTY:   shadow_cfg.max_duty = val;
            svpd_pkg::CFG_MIN_DUTY:   shadow_cfg.min_duty = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_volt(logic signed [15:0] va, logic signed [15:0] vb);
        volt_req_t q;
        q.va = va;
        q.vb = vb;
        q.drain = 0;
        pending_reqs.push_back(q);
    endtask

    // Random voltage, mostly scaled down so that both linear and overmodulated cases occur
    function automatic logic signed [15:0] rand_volt();
        logic signed [15:0] v;
        v = 16'($urandom);
        if ($urandom_range(0, 3) != 0)
            v = v >>> $urandom_range(0, 15);
        return v;
    endfunction

    initial
    begin
        logic [15:0] settings[7][4];
        volt_req_t mark;
        settings = '{
            '{svpd_pkg::RST_VBUS_GAIN, svpd_pkg::RST_PWM_PERIOD,
              svpd_pkg::RST_MAX_DUTY, svpd_pkg::RST_MIN_DUTY},
            '{16'd0, 16'd1, 16'd65535, 16'd0},
            '{16'd65535, 16'd65535, 16'd65535, 16'd0},
            '{16'd40, 16'd0, 16'd30000, 16'd0},
            '{16'd1, 16'd3000, 16'd20000, 16'd40000},
            '{16'd300, 16'd65535, 16'd65535, 16'd65535},
            '{16'd0, 16'd0, 16'd0, 16'd0}
        };
        settings[6] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
        shadow_cfg = '{svpd_pkg::RST_VBUS_GAIN, svpd_pkg::RST_PWM_PERIOD,
                       svpd_pkg::RST_MAX_DUTY, svpd_pkg::RST_MIN_DUTY};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero vector, extremes, axes and one vector per sector
        push_volt(16'sd0, 16'sd0);
        push_volt(-16'sd32768, -16'sd32768);
        push_volt(16'sd32767, 16'sd32767);
        push_volt(16'sd32767, -16'sd32768);
        push_volt(-16'sd32768, 16'sd32767);
        push_volt(16'sd100, 16'sd0);
        push_volt(-16'sd100, 16'sd0);
        push_volt(16'sd0, 16'sd100);
        push_volt(16'sd0, -16'sd100);
        push_volt(16'sd200, 16'sd50);
        push_volt(16'sd10, 16'sd200);
        push_volt(-16'sd200, 16'sd50);
        push_volt(-16'sd200, -16'sd50);
        push_volt(16'sd10, -16'sd200);
        push_volt(16'sd200, -16'sd50);
        push_volt(16'sd3, 16'sd1);
        push_volt(-16'sd1, -16'sd1);
        wait_drained();

        // Writes to spare indexes must leave the registers alone
        for (int k = 0; k < 4; k++)
            write_reg(svpd_pkg::CFG_INDEX_W'(CFG_SPARE + k), 16'($urandom));
        push_volt(16'sd500, 16'sd300);

        for (int ph = 0; ph < 7; ph++)
        begin
            wait_drained();
            write_reg(svpd_pkg::CFG_VBUS_GAIN, settings[ph][0]);
            write_reg(svpd_pkg::CFG_PWM_PERIOD, settings[ph][1]);
            write_reg(svpd_pkg::CFG_MAX_DUTY, settings[ph][2]);
            write_reg(svpd_pkg::CFG_MIN_DUTY, settings[ph][3]);
            calm = (ph == 4);
            if (ph == 2)
                choke_start = 1;
            for (int n = 0; n < 250; n++)
            begin
                // Pause the sender until every result is back
                if (ph == 3 && n == 120)
                begin
                    mark.va = '0;
                    mark.vb = '0;
                    mark.drain = 1;
                    pending_reqs.push_back(mark);
                end
                push_volt(rand_volt(), rand_volt());
            end
        end
        wait_drained();
        calm = 0;

        if (fail_count == 0 && expected_duties.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/svpd_pkg.sv
hw/rtl/svpd_front.sv
hw/rtl/svpd_queue.sv
hw/rtl/svpd_back.sv
hw/rtl/space_vector_pwm_duty.sv
dv/space_vector_pwm_duty_test.sv
